@@ rtl/segmented_register_rename_unit_assert.svh @@
// Assertion helpers for the checker file.
`ifndef SEGMENTED_REGISTER_RENAME_UNIT_ASSERT_SVH
`define SEGMENTED_REGISTER_RENAME_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SRR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srr assertion failed");

// next-cycle implication
`define SRR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srr assertion failed");

`endif

@@ rtl/srr_pkg.sv @@
// ----------------------------------------------------------------------------
// srr_pkg
// Sizes, codes and controller/datapath interface types of the rename unit.
// ----------------------------------------------------------------------------
package srr_pkg;

  localparam int ARCH_REGS = 64;
  localparam int PHYS_REGS = 128;
  localparam int SEGMENTS  = 4;
  localparam int BLOCKS    = 16;

  localparam int A_SEG = ARCH_REGS / SEGMENTS;
  localparam int P_SEG = PHYS_REGS / SEGMENTS;
  localparam int BPS   = ((BLOCKS / SEGMENTS) > 0) ? (BLOCKS / SEGMENTS) : 1;

  localparam int AW = $clog2(ARCH_REGS);
  localparam int PW = $clog2(PHYS_REGS);
  localparam int SW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam int CW = $clog2(P_SEG + 1);
  localparam int XW = PW + 1;

  typedef enum logic [3:0] {
    OP_LOOKUP    = 4'd0,
    OP_ALLOC     = 4'd1,
    OP_FETCHMAP  = 4'd2,
    OP_COMMITMAP = 4'd3,
    OP_RELEASE   = 4'd4,
    OP_SETSTATE  = 4'd5,
    OP_LINKPREV  = 4'd6,
    OP_SQUASHONE = 4'd7,
    OP_SQUASHALL = 4'd8,
    OP_QUERY     = 4'd9
  } op_t;

  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_NONE_FREE = 3'd1,
    ERR_ILLEGAL   = 3'd2,
    ERR_RANGE     = 3'd3,
    ERR_FULL      = 3'd4
  } err_t;

  localparam logic [1:0] ST_AVAIL = 2'd0;
  localparam logic [1:0] ST_RINV  = 2'd1;
  localparam logic [1:0] ST_RVAL  = 2'd2;
  localparam logic [1:0] ST_ARCH  = 2'd3;

  localparam logic CFG_ARCH_BASE = 1'b0;
  localparam logic CFG_PHYS_BASE = 1'b1;

  typedef struct packed {
    logic          init;
    logic          capture;
    logic          exec;
    logic          alloc_fin;
    logic          sqa;
    logic          sqb;
    logic          sq_fin;
    logic [XW-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic alloc_hit;
  } sts_t;

endpackage

@@ rtl/segmented_register_rename_unit.sv @@
// ----------------------------------------------------------------------------
// segmented_register_rename_unit
// Segmented register renamer with per-segment free stacks.
// ----------------------------------------------------------------------------
// One op at a time. After reset the tables are loaded by a sweep over
// every physical register (in_stall high). Each op then steps through
// map/state read, dependent state read for commit-map, execute and result;
// a successful allocate adds a free-stack read before the result.
// Squash-all then sweeps one commit-map entry then one physical register
// per cycle over the single-write-port tables. The next input beat is
// taken in the cycle after the result beat leaves. Config writes are
// always taken.
module segmented_register_rename_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [3:0] in_opcode,
  input  logic [8:0] in_arch_reg,
  input  logic [8:0] in_phys_reg,
  input  logic [8:0] in_prev_phys,
  input  logic [3:0] in_block_index,
  input  logic [1:0] in_new_state,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [8:0] out_phys_out,
  output logic [1:0] out_state_out,
  output logic       out_data_valid,
  output logic [8:0] out_prev_out,
  output logic       out_prev_present,
  output logic [7:0] out_free_total,
  output logic       out_local_alloc,
  output logic [2:0] out_error_code
);
  import srr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  srr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  srr_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_valid & cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_opcode        (in_opcode),
    .in_arch_reg      (in_arch_reg),
    .in_phys_reg      (in_phys_reg),
    .in_prev_phys     (in_prev_phys),
    .in_block_index   (in_block_index),
    .in_new_state     (in_new_state),
    .cmd              (cmd),
    .sts              (sts),
    .out_phys_out     (out_phys_out),
    .out_state_out    (out_state_out),
    .out_data_valid   (out_data_valid),
    .out_prev_out     (out_prev_out),
    .out_prev_present (out_prev_present),
    .out_free_total   (out_free_total),
    .out_local_alloc  (out_local_alloc),
    .out_error_code   (out_error_code)
  );

endmodule

@@ rtl/srr_ctrl.sv @@
// ----------------------------------------------------------------------------
// srr_ctrl
// Sequencer: init sweep, per-op read/execute steps, squash-all sweeps.
// ----------------------------------------------------------------------------
module srr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  srr_pkg::sts_t sts,
  output srr_pkg::cmd_t cmd
);
  import srr_pkg::*;

  typedef enum logic [9:0] {
    S_INIT  = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_RD    = 10'b0000000100,
    S_CM    = 10'b0000001000,
    S_EXEC  = 10'b0000010000,
    S_ALLOC = 10'b0000100000,
    S_SQA   = 10'b0001000000,
    S_SQB   = 10'b0010000000,
    S_SQF   = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t        state_r, state_nxt;
  logic [XW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.cnt   = cnt_r;
    unique case (state_r)
      S_INIT: begin
        cmd.init = 1'b1;
        if (cnt_r == XW'(PHYS_REGS - 1)) begin
          state_nxt = S_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_RD;
        end
      end
      S_RD: state_nxt = S_CM;
      S_CM: state_nxt = S_EXEC;
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.op == OP_SQUASHALL) begin
          state_nxt = S_SQA;
          cnt_nxt   = '0;
        end else if (sts.op == OP_ALLOC && sts.alloc_hit) begin
          state_nxt = S_ALLOC;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_ALLOC: begin
        cmd.alloc_fin = 1'b1;
        state_nxt     = S_DONE;
      end
      S_SQA: begin
        cmd.sqa = 1'b1;
        if (cnt_r == XW'(ARCH_REGS)) begin
          state_nxt = S_SQB;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SQB: begin
        cmd.sqb = 1'b1;
        if (cnt_r == XW'(PHYS_REGS - 1)) begin
          state_nxt = S_SQF;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SQF: begin
        cmd.sq_fin = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule

@@ rtl/srr_dp.sv @@
// ----------------------------------------------------------------------------
// srr_dp
// Maps, register state, links, free stacks and the result register.
// ----------------------------------------------------------------------------
module srr_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [7:0]    cfg_data,
  input  logic [3:0]    in_opcode,
  input  logic [8:0]    in_arch_reg,
  input  logic [8:0]    in_phys_reg,
  input  logic [8:0]    in_prev_phys,
  input  logic [3:0]    in_block_index,
  input  logic [1:0]    in_new_state,
  input  srr_pkg::cmd_t cmd,
  output srr_pkg::sts_t sts,
  output logic [8:0]    out_phys_out,
  output logic [1:0]    out_state_out,
  output logic          out_data_valid,
  output logic [8:0]    out_prev_out,
  output logic          out_prev_present,
  output logic [7:0]    out_free_total,
  output logic          out_local_alloc,
  output logic [2:0]    out_error_code
);
  import srr_pkg::*;

  logic [7:0] arch_base_r, phys_base_r;

  // captured operands
  op_t           op_r;
  logic [AW-1:0] a_idx_r;
  logic [PW-1:0] p_idx_r, q_idx_r;
  logic          a_ok_r, p_ok_r, q_ok_r;
  logic [3:0]    blk_r;
  logic [1:0]    ns_r;

  logic [9:0] a_diff, p_diff, q_diff;

  // storage
  logic [PW-1:0] fm_mem [ARCH_REGS];
  logic [PW-1:0] cm_mem [ARCH_REGS];
  logic [1:0]    st_mem [PHYS_REGS];
  logic [PW:0]   lk_mem [PHYS_REGS];
  logic [PW-1:0] fs_mem [PHYS_REGS];
  logic [PW-1:0] fm_q, cm_q, fs_q;
  logic [1:0]    stp_q, stc_q;
  logic [PW:0]   lk_q;

  logic [CW-1:0]        fc_r   [SEGMENTS];
  logic [CW-1:0]        fc_nxt [SEGMENTS];
  logic [PHYS_REGS-1:0] cmt_r;

  // write ports
  logic          fm_we, cm_we, st_we, lk_we, fs_we;
  logic [AW-1:0] fm_wa, cm_wa, cm_ra;
  logic [PW-1:0] fm_wd, cm_wd, st_wa, lk_wa, fs_wa, fs_wd, fs_ra;
  logic [1:0]    st_wd;
  logic [PW:0]   lk_wd;
  logic          cmt_set, cmt_clr;
  logic [PW-1:0] cmt_idx;

  // execute results
  err_t          ex_err;
  logic [1:0]    st_post;
  logic [PW:0]   lk_post;
  logic [8:0]    ex_phys;
  logic          ex_local;
  logic          hit;
  logic [SW-1:0] home, aseg;
  logic [7:0]    tot;

  assign a_diff = {1'b0, in_arch_reg} - {2'b0, arch_base_r};
  assign p_diff = {1'b0, in_phys_reg} - {2'b0, phys_base_r};
  assign q_diff = {1'b0, in_prev_phys} - {2'b0, phys_base_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arch_base_r <= 8'd0;
      phys_base_r <= 8'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ARCH_BASE: arch_base_r <= cfg_data;
        CFG_PHYS_BASE: phys_base_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= op_t'(in_opcode);
      a_idx_r <= a_diff[AW-1:0];
      p_idx_r <= p_diff[PW-1:0];
      q_idx_r <= q_diff[PW-1:0];
      a_ok_r  <= !a_diff[9] && ({1'b0, a_diff[8:0]} < 10'(ARCH_REGS));
      p_ok_r  <= !p_diff[9] && ({1'b0, p_diff[8:0]} < 10'(PHYS_REGS));
      q_ok_r  <= !q_diff[9] && ({1'b0, q_diff[8:0]} < 10'(PHYS_REGS));
      blk_r   <= in_block_index;
      ns_r    <= in_new_state;
    end
  end

  // home segment and wrap-around search, starting at home, for a non-empty stack
  always_comb begin
    int t;
    hit  = 1'b0;
    aseg = '0;
    if (int'(blk_r) / BPS >= SEGMENTS) home = SW'(SEGMENTS - 1);
    else home = SW'(int'(blk_r) / BPS);
    for (int n = 0; n < SEGMENTS; n++) begin
      t = int'(home) + n;
      if (t >= SEGMENTS) t = t - SEGMENTS;
      if (!hit && fc_r[t] != '0) begin
        hit  = 1'b1;
        aseg = SW'(t);
      end
    end
  end

  assign sts.op        = op_r;
  assign sts.alloc_hit = hit && (int'(blk_r) < BLOCKS);

  always_comb begin
    int j, sg;
    j  = int'(cmd.cnt[PW-1:0]);
    sg = 0;
    fm_we = 1'b0; fm_wa = '0; fm_wd = '0;
    cm_we = 1'b0; cm_wa = '0; cm_wd = '0;
    st_we = 1'b0; st_wa = '0; st_wd = ST_AVAIL;
    lk_we = 1'b0; lk_wa = '0; lk_wd = '0;
    fs_we = 1'b0; fs_wa = '0; fs_wd = '0;
    cmt_set = 1'b0; cmt_clr = 1'b0; cmt_idx = '0;
    cm_ra   = cmd.sqa ? cmd.cnt[AW-1:0] : a_idx_r;
    fs_ra   = PW'(int'(aseg) * P_SEG + int'(fc_r[aseg]) - 1);
    ex_err   = ERR_OK;
    st_post  = stp_q;
    lk_post  = lk_q;
    ex_phys  = '0;
    ex_local = 1'b0;
    fc_nxt   = fc_r;
    priority if (cmd.init) begin
      // reset image: identity map per segment, rest of each segment free
      if (j < ARCH_REGS) begin
        fm_we = 1'b1;
        cm_we = 1'b1;
        fm_wa = AW'(j);
        cm_wa = AW'(j);
        fm_wd = PW'((j / A_SEG) * P_SEG + (j % A_SEG));
        cm_wd = PW'((j / A_SEG) * P_SEG + (j % A_SEG));
      end
      st_we = 1'b1;
      st_wa = PW'(j);
      st_wd = ((j % P_SEG) < A_SEG) ? ST_ARCH : ST_AVAIL;
      lk_we = 1'b1;
      lk_wa = PW'(j);
      if ((j % P_SEG) >= A_SEG) begin
        fs_we = 1'b1;
        fs_wa = PW'((j / P_SEG) * P_SEG + (j % P_SEG) - A_SEG);
        fs_wd = PW'(j);
      end
    end else if (cmd.sqa) begin
      // read data is registered and arrives in the cycle after its address
      if (cmd.cnt != '0) begin
        fm_we   = 1'b1;
        fm_wa   = AW'(int'(cmd.cnt) - 1);
        fm_wd   = cm_q;
        cmt_set = 1'b1;
        cmt_idx = cm_q;
      end
    end else if (cmd.sqb) begin
      st_we = 1'b1;
      st_wa = PW'(j);
      st_wd = cmt_r[j] ? ST_ARCH : ST_AVAIL;
      lk_we = 1'b1;
      lk_wa = PW'(j);
      sg    = j / P_SEG;
      if (!cmt_r[j] && sg < SEGMENTS && int'(fc_r[sg]) < P_SEG) begin
        fs_we      = 1'b1;
        fs_wa      = PW'(sg * P_SEG + int'(fc_r[sg]));
        fs_wd      = PW'(j);
        fc_nxt[sg] = fc_r[sg] + 1'b1;
      end
    end else if (cmd.exec) begin
      unique case (op_r)
        OP_LOOKUP: begin
          if (!a_ok_r) ex_err = ERR_RANGE;
          else ex_phys = 9'(phys_base_r) + 9'(fm_q);
        end
        OP_ALLOC: begin
          if (int'(blk_r) >= BLOCKS) ex_err = ERR_RANGE;
          else if (!hit) ex_err = ERR_NONE_FREE;
          else begin
            fc_nxt[aseg] = fc_r[aseg] - 1'b1;
            ex_local     = (aseg == home);
          end
        end
        OP_FETCHMAP: begin
          if (!a_ok_r || !p_ok_r) ex_err = ERR_RANGE;
          else if (stp_q != ST_AVAIL) ex_err = ERR_ILLEGAL;
          else begin
            fm_we = 1'b1;
            fm_wa = a_idx_r;
            fm_wd = p_idx_r;
          end
        end
        OP_COMMITMAP: begin
          if (!a_ok_r || !p_ok_r) ex_err = ERR_RANGE;
          else if (stc_q != ST_AVAIL || stp_q != ST_ARCH) ex_err = ERR_ILLEGAL;
          else begin
            cm_we = 1'b1;
            cm_wa = a_idx_r;
            cm_wd = p_idx_r;
          end
        end
        OP_RELEASE: begin
          sg = int'(p_idx_r) / P_SEG;
          if (!p_ok_r) ex_err = ERR_RANGE;
          else if (sg >= SEGMENTS || int'(fc_r[sg]) >= P_SEG) ex_err = ERR_FULL;
          else begin
            fs_we      = 1'b1;
            fs_wa      = PW'(sg * P_SEG + int'(fc_r[sg]));
            fs_wd      = p_idx_r;
            fc_nxt[sg] = fc_r[sg] + 1'b1;
            lk_we      = 1'b1;
            lk_wa      = p_idx_r;
            lk_post    = '0;
          end
        end
        OP_SETSTATE: begin
          if (!p_ok_r) ex_err = ERR_RANGE;
          else if (ns_r != stp_q + 2'd1) ex_err = ERR_ILLEGAL;
          else begin
            st_we   = 1'b1;
            st_wa   = p_idx_r;
            st_wd   = ns_r;
            st_post = ns_r;
          end
        end
        OP_LINKPREV: begin
          if (!p_ok_r || !q_ok_r) ex_err = ERR_RANGE;
          else if (stp_q != ST_AVAIL || ns_r != ST_RINV) ex_err = ERR_ILLEGAL;
          else begin
            st_we   = 1'b1;
            st_wa   = p_idx_r;
            st_wd   = ST_RINV;
            st_post = ST_RINV;
            lk_we   = 1'b1;
            lk_wa   = p_idx_r;
            lk_wd   = {1'b1, q_idx_r};
            lk_post = {1'b1, q_idx_r};
          end
        end
        OP_SQUASHONE: begin
          if (!p_ok_r) ex_err = ERR_RANGE;
          else if (stp_q != ST_RINV && stp_q != ST_RVAL) ex_err = ERR_ILLEGAL;
          else begin
            st_we   = 1'b1;
            st_wa   = p_idx_r;
            st_wd   = ST_AVAIL;
            st_post = ST_AVAIL;
          end
        end
        OP_SQUASHALL: begin
          cmt_clr = 1'b1;
          for (int s = 0; s < SEGMENTS; s++) fc_nxt[s] = '0;
        end
        OP_QUERY: begin
          if (!p_ok_r) ex_err = ERR_RANGE;
        end
        default: ex_err = ERR_RANGE;
      endcase
    end
  end

  always_comb begin
    tot = '0;
    for (int s = 0; s < SEGMENTS; s++) tot = tot + 8'(fc_nxt[s]);
  end

  always_ff @(posedge clk) begin
    if (fm_we) fm_mem[fm_wa] <= fm_wd;
    fm_q <= fm_mem[a_idx_r];
  end

  always_ff @(posedge clk) begin
    if (cm_we) cm_mem[cm_wa] <= cm_wd;
    cm_q <= cm_mem[cm_ra];
  end

  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_wa] <= st_wd;
    stp_q <= st_mem[p_idx_r];
    stc_q <= st_mem[cm_q];
  end

  always_ff @(posedge clk) begin
    if (lk_we) lk_mem[lk_wa] <= lk_wd;
    lk_q <= lk_mem[p_idx_r];
  end

  always_ff @(posedge clk) begin
    if (fs_we) fs_mem[fs_wa] <= fs_wd;
    fs_q <= fs_mem[fs_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SEGMENTS; s++) fc_r[s] <= CW'(P_SEG - A_SEG);
    end else begin
      for (int s = 0; s < SEGMENTS; s++) fc_r[s] <= fc_nxt[s];
    end
  end

  always_ff @(posedge clk) begin
    if (cmt_clr) cmt_r <= '0;
    else if (cmt_set) cmt_r[cmt_idx] <= 1'b1;
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_phys_out     <= ex_phys;
      out_state_out    <= p_ok_r ? st_post : 2'd0;
      out_data_valid   <= p_ok_r && st_post[1];
      out_prev_present <= p_ok_r && lk_post[PW];
      out_prev_out     <= (p_ok_r && lk_post[PW]) ?
                          9'(phys_base_r) + 9'(lk_post[PW-1:0]) : 9'd0;
      out_free_total   <= tot;
      out_local_alloc  <= ex_local;
      out_error_code   <= ex_err;
    end else if (cmd.alloc_fin) begin
      out_phys_out <= 9'(phys_base_r) + 9'(fs_q);
    end else if (cmd.sq_fin) begin
      out_phys_out     <= '0;
      out_state_out    <= (p_ok_r && cmt_r[p_idx_r]) ? ST_ARCH : ST_AVAIL;
      out_data_valid   <= p_ok_r && cmt_r[p_idx_r];
      out_prev_present <= 1'b0;
      out_prev_out     <= '0;
      out_free_total   <= tot;
      out_local_alloc  <= 1'b0;
      out_error_code   <= ERR_OK;
    end
  end

endmodule

@@ rtl/srr_chk.sv @@
// ----------------------------------------------------------------------------
// srr_chk
// Port-level checks on the rename unit result channel.
// ----------------------------------------------------------------------------
`include "segmented_register_rename_unit_assert.svh"

module srr_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [8:0] out_prev_out,
  input logic       out_prev_present,
  input logic [7:0] out_free_total,
  input logic       out_local_alloc,
  input logic [2:0] out_error_code
);
  import srr_pkg::*;

  `SRR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  // one op in flight: no new beat while a result is pending
  `SRR_ASSERT_IMPL(a_one_op, out_valid, in_stall)
  `SRR_ASSERT_IMPL(a_local_ok, out_valid && out_local_alloc, out_error_code == 3'(ERR_OK))
  `SRR_ASSERT_IMPL(a_no_link, out_valid && !out_prev_present, out_prev_out == 9'd0)
  `SRR_ASSERT_IMPL(a_total, out_valid && in_valid, 9'(out_free_total) <= 9'(PHYS_REGS))

endmodule

bind segmented_register_rename_unit srr_chk u_srr_chk (.*);
